@@ src/ltc_pkg.sv @@
// ============================================================================
// ltc_pkg: shared definitions for the LRU tag cache
// Slot count, field widths, operation codes and the controller command bundle.
// ============================================================================
package ltc_pkg;

    localparam int SLOTS        = 16;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int KEY_W        = 32;
    localparam int OP_W         = 2;
    localparam int SLOT_FIELD_W = 4;

    localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
    localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    typedef logic [SLOT_W-1:0] slot_t;

    // Commands from the controller to the datapath, one phase each.
    typedef struct packed {
        logic load;
        logic lookup;
        logic update;
    } ltc_cmd_t;

endpackage

@@ src/ltc_ctrl.sv @@
// ============================================================================
// ltc_ctrl: transfer sequencer
// Steps each accepted transfer through a lookup phase and an update phase.
// ============================================================================
module ltc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output ltc_pkg::ltc_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                    busy_next  = 1'b1;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
                busy_next  = 1'b1;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign cmd.load   = (state_reg == ST_IDLE) && start;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.update = (state_reg == ST_UPDATE);

endmodule

@@ src/ltc_recency.sv @@
// ============================================================================
// ltc_recency: true LRU order cells
// Cell 0 holds the least recent slot, the last cell the most recent one.
// ============================================================================
module ltc_recency
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          move,
    input  ltc_pkg::slot_t target,
    output ltc_pkg::slot_t oldest
);

    localparam int LAST = ltc_pkg::SLOTS - 1;

    ltc_pkg::slot_t order_reg  [ltc_pkg::SLOTS];
    ltc_pkg::slot_t order_next [ltc_pkg::SLOTS];
    logic [ltc_pkg::SLOTS-1:0] sel;
    ltc_pkg::slot_t pos;

    // Every slot number sits in exactly one cell, so an OR of the selected
    // cell numbers gives the position of the target.
    always_comb
    begin
        pos = '0;
        for (int k = 0; k < ltc_pkg::SLOTS; k++)
        begin
            sel[k] = (order_reg[k] == target);
            if (sel[k])
            begin
                pos = pos | ltc_pkg::slot_t'(k);
            end
        end
    end

    // Cells from the target onward take their successor; the target goes last.
    always_comb
    begin
        for (int k = 0; k < LAST; k++)
        begin
            if (ltc_pkg::slot_t'(k) >= pos)
            begin
                order_next[k] = order_reg[k+1];
            end
            else
            begin
                order_next[k] = order_reg[k];
            end
        end
        order_next[LAST] = target;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ltc_pkg::SLOTS; k++)
            begin
                order_reg[k] <= ltc_pkg::slot_t'(k);
            end
        end
        else if (move)
        begin
            for (int k = 0; k < ltc_pkg::SLOTS; k++)
            begin
                order_reg[k] <= order_next[k];
            end
        end
    end

    assign oldest = order_reg[0];

    a_target_unique: assert property (@(posedge clk) disable iff (!rst_n)
        move |-> $onehot(sel))
        else $error("recency cells do not hold the target exactly once");

    a_oldest_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(oldest))
        else $error("least recent slot changed without an update");

    a_target_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> order_reg[LAST] == $past(target))
        else $error("moved slot is not most recent");

endmodule

@@ src/ltc_datapath.sv @@
// ============================================================================
// ltc_datapath: key store, associative compare and result registers
// Holds the slot keys and the LRU cells and forms each result.
// ============================================================================
module ltc_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ltc_pkg::ltc_cmd_t                   cmd,
    input  logic [ltc_pkg::OP_W-1:0]            op,
    input  logic [ltc_pkg::KEY_W-1:0]           key_hash,
    input  logic [ltc_pkg::SLOT_FIELD_W-1:0]    slot_index,
    output logic                                hit,
    output logic [ltc_pkg::SLOT_FIELD_W-1:0]    slot,
    output logic [ltc_pkg::KEY_W-1:0]           stored_key
);

    logic [ltc_pkg::OP_W-1:0]         op_reg;
    logic [ltc_pkg::KEY_W-1:0]        key_reg;
    logic [ltc_pkg::SLOT_FIELD_W-1:0] idx_reg;

    logic [ltc_pkg::KEY_W-1:0] key_mem [ltc_pkg::SLOTS];
    logic [ltc_pkg::SLOTS-1:0] valid_reg;

    logic                lk_hit_reg;
    ltc_pkg::slot_t      lk_slot_reg;

    logic                                hit_reg;
    logic                                hit_next;
    logic [ltc_pkg::SLOT_FIELD_W-1:0]    slot_reg;
    logic [ltc_pkg::SLOT_FIELD_W-1:0]    slot_next;
    logic [ltc_pkg::KEY_W-1:0]           stored_reg;
    logic [ltc_pkg::KEY_W-1:0]           stored_next;

    logic [ltc_pkg::SLOTS-1:0] match;
    ltc_pkg::slot_t            match_slot;
    ltc_pkg::slot_t            oldest;
    logic                      move;
    logic                      fill;
    logic                      idx_in_range;
    ltc_pkg::slot_t            idx_slot;
    logic [ltc_pkg::KEY_W-1:0] idx_key;

    // A slot never written reads and compares as the key zero.
    always_comb
    begin
        match_slot = '0;
        for (int s = 0; s < ltc_pkg::SLOTS; s++)
        begin
            match[s] = valid_reg[s] ? (key_mem[s] == key_reg) : (key_reg == '0);
        end
        for (int s = ltc_pkg::SLOTS - 1; s >= 0; s--)
        begin
            if (match[s])
            begin
                match_slot = ltc_pkg::slot_t'(s);
            end
        end
    end

    assign move = cmd.update && (op_reg == ltc_pkg::OP_ACCESS);
    assign fill = move && !lk_hit_reg;

    assign idx_in_range = (32'(idx_reg) < 32'(ltc_pkg::SLOTS));
    assign idx_slot     = idx_reg[ltc_pkg::SLOT_W-1:0];
    assign idx_key      = valid_reg[idx_slot] ? key_mem[idx_slot] : '0;

    always_comb
    begin
        hit_next    = 1'b0;
        slot_next   = '0;
        stored_next = '0;
        case (op_reg)
            ltc_pkg::OP_ACCESS:
            begin
                hit_next    = lk_hit_reg;
                slot_next   = ltc_pkg::SLOT_FIELD_W'(lk_slot_reg);
                stored_next = key_reg;
            end
            ltc_pkg::OP_PROBE:
            begin
                hit_next = lk_hit_reg;
                if (lk_hit_reg)
                begin
                    slot_next   = ltc_pkg::SLOT_FIELD_W'(lk_slot_reg);
                    stored_next = key_reg;
                end
                else
                begin
                    stored_next = '1;
                end
            end
            ltc_pkg::OP_READ:
            begin
                slot_next = idx_reg;
                if (idx_in_range)
                begin
                    hit_next    = 1'b1;
                    stored_next = idx_key;
                end
            end
            default:
            begin
                hit_next    = 1'b0;
                slot_next   = '0;
                stored_next = '0;
            end
        endcase
    end

    ltc_recency u_recency
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .move   (move),
        .target (lk_slot_reg),
        .oldest (oldest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (fill)
        begin
            valid_reg[lk_slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            key_reg <= key_hash;
            idx_reg <= slot_index;
        end
        if (cmd.lookup)
        begin
            lk_hit_reg  <= |match;
            lk_slot_reg <= (|match) ? match_slot : oldest;
        end
        if (fill)
        begin
            key_mem[lk_slot_reg] <= key_reg;
        end
        if (cmd.update)
        begin
            hit_reg    <= hit_next;
            slot_reg   <= slot_next;
            stored_reg <= stored_next;
        end
    end

    assign hit        = hit_reg;
    assign slot       = slot_reg;
    assign stored_key = stored_reg;

endmodule

@@ src/lru_tag_cache.sv @@
// ============================================================================
// lru_tag_cache: fully associative tag store with true LRU replacement
// Access, probe and slot read of a 16-slot key store; one result per transfer.
// ============================================================================
// A transfer passes a lookup phase and an update phase, then shows its result; a new
// transfer is accepted in the result cycle at the earliest, once the block is idle again.
// busy stays high for both phases and drops together with the done strobe.
// The receiver cannot stall; each result is flagged by done for exactly one cycle.
// Reset (rst_n low, asynchronous) marks every slot empty, so each reads as an all-zero key,
// and restores the LRU order to slot i at position i; no clearing pass is needed.
// ============================================================================
module lru_tag_cache
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ltc_pkg::OP_W-1:0]            op,
    input  logic [ltc_pkg::KEY_W-1:0]           key_hash,
    input  logic [ltc_pkg::SLOT_FIELD_W-1:0]    slot_index,
    output logic                                done,
    output logic                                hit,
    output logic [ltc_pkg::SLOT_FIELD_W-1:0]    slot,
    output logic [ltc_pkg::KEY_W-1:0]           stored_key
);

    ltc_pkg::ltc_cmd_t cmd;

    // The controller owns the handshake. In the lookup phase all keys are
    // compared with the captured key at once and the lowest matching slot is
    // chosen; on a miss the least recent slot is chosen instead.
    ltc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // In the update phase the chosen slot moves to most recent (on an access),
    // an access miss installs the new key, and the result registers are loaded so that
    // they line up with the done strobe.
    ltc_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op         (op),
        .key_hash   (key_hash),
        .slot_index (slot_index),
        .hit        (hit),
        .slot       (slot),
        .stored_key (stored_key)
    );

    // A result only follows a busy phase.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transfer in flight");

    // The block is free again in the cycle that carries the result.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("block still busy while the result is shown");

    // An accepted transfer stays busy through both phases, and its done strobe
    // follows the update phase.
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 busy ##1 done)
        else $error("result did not arrive three edges after acceptance");

endmodule
